// ===== hdl/lagrange_basis_coefficients_defines.svh =====
// assertion macros for the lagrange basis coefficient block
`ifndef LAGRANGE_BASIS_COEFFICIENTS_DEFINES_SVH
`define LAGRANGE_BASIS_COEFFICIENTS_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define LBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define LBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lbc_pkg.sv =====
// shared constants, types and helpers for the lagrange basis coefficient block
package lbc_pkg;

	localparam int MAX_POINTS = 8;
	localparam int COORD_W    = 32;
	localparam int COEF_W     = 48;
	localparam int FRAC_W     = 24;
	localparam int IDX_W      = 3;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int PROD_W     = COEF_W + 2;
	localparam int WIDE_W     = COEF_W + 3;
	localparam int MAG_W      = COEF_W + 1;

	localparam logic signed [COEF_W-1:0] ONE_Q24 = COEF_W'(64'sd1 <<< FRAC_W);
	localparam logic signed [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PT_START,
		ST_K_NEXT,
		ST_K_READ,
		ST_T_READ,
		ST_T_MUL,
		ST_T_WAIT,
		ST_D_MUL,
		ST_D_WAIT,
		ST_E_READ,
		ST_E_CALC,
		ST_E_WAIT,
		ST_E_PUT
	} lbc_state_t;

	function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [WIDE_W-1:0] v);
		logic signed [COEF_W-1:0] r;
		if (v > WIDE_W'(SAT_MAX))
			r = SAT_MAX;
		else if (v < WIDE_W'(SAT_MIN))
			r = SAT_MIN;
		else
			r = v[COEF_W-1:0];
		return r;
	endfunction

	function automatic logic [COEF_W-1:0] mag_coef(input logic signed [COEF_W-1:0] v);
		return v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
	endfunction

endpackage

// ===== hdl/lbc_mul.sv =====
// shared rounding multiplier: magnitude 48 x 32 in two 16-bit halves, result q26.24
module lbc_mul import lbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [COEF_W-1:0]        a,
	input  logic [COORD_W-1:0]       b,
	input  logic                     neg,
	output logic                     done,
	output logic signed [PROD_W-1:0] product
);

	localparam int ACC_W = COEF_W + COORD_W;
	localparam int PP_W  = COEF_W + 16;

	logic [1:0]              ph_q;
	logic                    done_q;
	logic [COEF_W-1:0]       a_q;
	logic [COORD_W-1:0]      b_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        acc_q;
	logic signed [PROD_W-1:0] product_q;

	logic [PP_W-1:0]  pp;
	logic [ACC_W-ACC_W+64:0] rq;
	logic [MAG_W-1:0] capped;

	always_comb begin
		pp = PP_W'(a_q) * PP_W'((ph_q == 2'd1) ? b_q[15:0] : b_q[31:16]);
		rq = {1'b0, acc_q[ACC_W-1:16]} + 65'(acc_q[15]);
		capped = (rq > 65'(MAG_CAP)) ? MAG_CAP : rq[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				2'd0: if (start) ph_q <= 2'd1;
				2'd1: ph_q <= 2'd2;
				2'd2: ph_q <= 2'd3;
				default: begin
					ph_q   <= 2'd0;
					done_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			2'd0: if (start) begin
				a_q   <= a;
				b_q   <= b;
				neg_q <= neg;
			end
			2'd1: acc_q <= ACC_W'(pp);
			2'd2: acc_q <= acc_q + {pp, 16'b0};
			default: product_q <= neg_q ? -PROD_W'(capped) : PROD_W'(capped);
		endcase
	end

	assign done    = done_q;
	assign product = product_q;

endmodule

// ===== hdl/lbc_div.sv =====
// restoring divider, one quotient bit per cycle: round(n * 2^24 / d), signed, saturated
module lbc_div import lbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [COEF_W-1:0]        n,
	input  logic [COEF_W-1:0]        d,
	input  logic                     neg,
	output logic                     done,
	output logic signed [COEF_W-1:0] quotient
);

	localparam int NUM_W = COEF_W + FRAC_W;
	localparam int CW    = $clog2(NUM_W + 1);

	logic                     run_q;
	logic                     fin_q;
	logic                     done_q;
	logic [CW-1:0]            cnt_q;
	logic [NUM_W-1:0]         num_q;
	logic [NUM_W-1:0]         q_q;
	logic [COEF_W-1:0]        r_q;
	logic [COEF_W-1:0]        d_q;
	logic                     neg_q;
	logic signed [COEF_W-1:0] quotient_q;

	logic [COEF_W:0]  r_sh;
	logic             fits;
	logic [COEF_W:0]  r_new;
	logic             round_up;
	logic [NUM_W:0]   qr;

	always_comb begin
		r_sh     = {r_q, num_q[NUM_W-1]};
		fits     = r_sh >= {1'b0, d_q};
		r_new    = r_sh - {1'b0, d_q};
		round_up = {r_q, 1'b0} >= {1'b0, d_q};
		qr       = {1'b0, q_q} + (NUM_W+1)'(round_up);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start && !run_q) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !run_q) begin
			num_q <= {n, {FRAC_W{1'b0}}};
			d_q   <= d;
			neg_q <= neg;
			r_q   <= '0;
			q_q   <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			r_q   <= fits ? r_new[COEF_W-1:0] : r_sh[COEF_W-1:0];
			q_q   <= {q_q[NUM_W-2:0], fits};
		end
		if (fin_q) begin
			if (neg_q)
				quotient_q <= (qr >= (NUM_W+1)'(MAG_CAP >> 1)) ? SAT_MIN : -qr[COEF_W-1:0];
			else
				quotient_q <= (qr > (NUM_W+1)'(SAT_MAX)) ? SAT_MAX : qr[COEF_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quotient_q;

endmodule

// ===== hdl/lagrange_basis_coefficients.sv =====
// lagrange basis polynomial coefficient generator, top level
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | coordinate, last_point
// out     | out | out_valid/out_stall | point_index, power_index, coefficient,
//         |     |                     | zero_denominator, last_result
//
// points load one per cycle while idle; the request with last_point starts the burst
// burst: per point, (n-1) factors, each a pass over the terms through the shared
// multiplier and then a denominator multiply; then per coefficient a division with
// the bit-serial divider, which is skipped for a duplicate point or zero denominator
// in_stall stays high for the whole burst; out_stall only delays the emit steps
// reset clears the point count, sequencer and output valid; stores need no clearing
`include "lagrange_basis_coefficients_defines.svh"
module lagrange_basis_coefficients import lbc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [COORD_W-1:0] coordinate,
	input  logic                     last_point,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [IDX_W-1:0]         point_index,
	output logic [IDX_W-1:0]         power_index,
	output logic signed [COEF_W-1:0] coefficient,
	output logic                     zero_denominator,
	output logic                     last_result
);

	lbc_state_t state_q, state_d;

	logic [CNT_W-1:0] count_q, n_q, j_q, k_q, m_q, t_q, kk_q;

	logic signed [COORD_W-1:0] store_mem [0:MAX_POINTS-1];
	logic signed [COEF_W-1:0]  poly_mem [0:MAX_POINTS];

	logic signed [COORD_W-1:0] xk_q, xj_q;
	logic signed [COEF_W-1:0]  ct_q, cp_q, c_q, d_q, coef_q;
	logic                      dup_q;

	logic                      out_valid_q;
	logic [IDX_W-1:0]          point_index_q, power_index_q;
	logic signed [COEF_W-1:0]  coefficient_q;
	logic                      zero_den_q, last_result_q;

	logic                      in_take, out_free, out_load;
	logic                      mul_start, mul_neg, mul_done;
	logic [COEF_W-1:0]         mul_a;
	logic [COORD_W-1:0]        mul_b;
	logic signed [PROD_W-1:0]  mul_prod;
	logic                      div_start, div_done;
	logic signed [COEF_W-1:0]  div_coef;

	logic signed [COORD_W:0]   diff;
	logic [COORD_W:0]          diff_mag, xk_mag;
	logic [CNT_W-1:0]          count_inc, n_last;

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		diff      = (COORD_W+1)'(xj_q) - (COORD_W+1)'(xk_q);
		diff_mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
		xk_mag    = xk_q[COORD_W-1] ? -(COORD_W+1)'(xk_q) : (COORD_W+1)'(xk_q);
		count_inc = (count_q < CNT_W'(MAX_POINTS)) ? count_q + CNT_W'(1) : count_q;
		n_last    = n_q - CNT_W'(1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_take && last_point) state_d = ST_PT_START;
			ST_PT_START: state_d = ST_K_NEXT;
			ST_K_NEXT: begin
				if (k_q == n_q)
					state_d = ST_E_READ;
				else if (k_q != j_q)
					state_d = ST_K_READ;
			end
			ST_K_READ:   state_d = ST_T_READ;
			ST_T_READ:   state_d = ST_T_MUL;
			ST_T_MUL:    state_d = ST_T_WAIT;
			ST_T_WAIT:   if (mul_done) state_d = (t_q == CNT_W'(1)) ? ST_D_MUL : ST_T_READ;
			ST_D_MUL:    state_d = ST_D_WAIT;
			ST_D_WAIT:   if (mul_done) state_d = ST_K_NEXT;
			ST_E_READ:   state_d = ST_E_CALC;
			ST_E_CALC:   state_d = (dup_q || d_q == '0) ? ST_E_PUT : ST_E_WAIT;
			ST_E_WAIT:   if (div_done) state_d = ST_E_PUT;
			ST_E_PUT: begin
				if (out_free) begin
					if (kk_q != n_last)
						state_d = ST_E_READ;
					else
						state_d = (j_q == n_last) ? ST_IDLE : ST_PT_START;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		mul_start = (state_q == ST_T_MUL) || (state_q == ST_D_MUL);
		div_start = (state_q == ST_E_CALC) && !dup_q && (d_q != '0);
		out_load  = (state_q == ST_E_PUT) && out_free;
		if (state_q == ST_D_MUL) begin
			mul_a   = mag_coef(d_q);
			mul_b   = diff_mag[COORD_W-1:0];
			mul_neg = d_q[COEF_W-1] ^ diff[COORD_W];
		end else begin
			mul_a   = mag_coef(cp_q);
			mul_b   = xk_mag[COORD_W-1:0];
			mul_neg = cp_q[COEF_W-1] ^ xk_q[COORD_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			n_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			m_q         <= '0;
			t_q         <= '0;
			kk_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_take) begin
					if (last_point) begin
						n_q     <= count_inc;
						count_q <= '0;
						j_q     <= '0;
					end else
						count_q <= count_inc;
				end
				ST_PT_START: begin
					k_q <= '0;
					m_q <= '0;
				end
				ST_K_NEXT: begin
					if (k_q == n_q)
						kk_q <= '0;
					else if (k_q == j_q)
						k_q <= k_q + CNT_W'(1);
				end
				ST_K_READ: t_q <= m_q + CNT_W'(1);
				ST_T_WAIT: if (mul_done && t_q != CNT_W'(1)) t_q <= t_q - CNT_W'(1);
				ST_D_WAIT: if (mul_done) begin
					m_q <= m_q + CNT_W'(1);
					k_q <= k_q + CNT_W'(1);
				end
				ST_E_PUT: if (out_free) begin
					if (kk_q != n_last)
						kk_q <= kk_q + CNT_W'(1);
					else if (j_q != n_last)
						j_q <= j_q + CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && count_q < CNT_W'(MAX_POINTS))
			store_mem[count_q[IDX_W-1:0]] <= coordinate;
		case (state_q)
			ST_PT_START: begin
				d_q   <= ONE_Q24;
				dup_q <= 1'b0;
			end
			ST_K_READ: begin
				xk_q <= store_mem[k_q[IDX_W-1:0]];
				xj_q <= store_mem[j_q[IDX_W-1:0]];
			end
			// the term at index m+1 is still empty and term 0, the leading coefficient, is always 1.0
			ST_T_READ: begin
				ct_q <= (t_q == m_q + CNT_W'(1)) ? '0 : poly_mem[t_q];
				cp_q <= (t_q == CNT_W'(1)) ? ONE_Q24 : poly_mem[t_q - CNT_W'(1)];
			end
			ST_T_WAIT: if (mul_done)
				poly_mem[t_q] <= sat_coef(WIDE_W'(ct_q) - WIDE_W'(mul_prod));
			ST_D_MUL: if (diff == '0) dup_q <= 1'b1;
			ST_D_WAIT: if (mul_done) d_q <= sat_coef(WIDE_W'(mul_prod));
			ST_E_READ: c_q <= (kk_q == '0) ? ONE_Q24 : poly_mem[kk_q];
			ST_E_CALC: begin
				if (dup_q || c_q == '0)
					coef_q <= '0;
				else if (d_q == '0)
					coef_q <= c_q[COEF_W-1] ? SAT_MIN : SAT_MAX;
			end
			ST_E_WAIT: if (div_done) coef_q <= div_coef;
			default: ;
		endcase
		if (out_load) begin
			point_index_q <= j_q[IDX_W-1:0];
			power_index_q <= kk_q[IDX_W-1:0];
			coefficient_q <= coef_q;
			zero_den_q    <= dup_q;
			last_result_q <= (j_q == n_last) && (kk_q == n_last);
		end
	end

	lbc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.neg     (mul_neg),
		.done    (mul_done),
		.product (mul_prod)
	);

	lbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.n        (mag_coef(c_q)),
		.d        (mag_coef(d_q)),
		.neg      (c_q[COEF_W-1] ^ d_q[COEF_W-1]),
		.done     (div_done),
		.quotient (div_coef)
	);

	assign out_valid        = out_valid_q;
	assign point_index      = point_index_q;
	assign power_index      = power_index_q;
	assign coefficient      = coefficient_q;
	assign zero_denominator = zero_den_q;
	assign last_result      = last_result_q;

	`LBC_ASSERT_NOW(a_dup_zero, out_valid && zero_denominator, coefficient == '0, "duplicate point with nonzero coefficient")
	`LBC_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CNT_W'(MAX_POINTS), "point count above limit")
	`LBC_ASSERT_NEXT(a_burst_stall, in_valid && !in_stall && last_point, in_stall, "input not stalled after last point")
	`LBC_ASSERT_NOW(a_last_diag, out_valid && last_result, point_index == power_index, "last result not on final point and power")

endmodule

// ===== tb/lagrange_basis_coefficients_test.sv =====
// testbench for the lagrange basis coefficient generator
module lagrange_basis_coefficients_test;
	import lbc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		logic [IDX_W-1:0] power_index;
		logic signed [COEF_W-1:0] coefficient;
		logic zero_denominator;
		logic last_result;
	} coef_t;

	class basis_scoreboard;
		longint points[MAX_POINTS];
		int n_points;
		coef_t pending[$];
		int mismatches;
		int checked;
		int bursts;

		function new();
			n_points = 0;
			mismatches = 0;
			checked = 0;
			bursts = 0;
		endfunction

		function longint clamp(longint v);
			longint r;
			r = v;
			if (v > 64'sh7FFF_FFFF_FFFF)
				r = 64'sh7FFF_FFFF_FFFF;
			else if (v < -64'sh8000_0000_0000)
				r = -64'sh8000_0000_0000;
			return r;
		endfunction

		function longint absval(longint v);
			return v < 0 ? -v : v;
		endfunction

		// rounded product of q24 by q16, magnitude capped at 2^48
		function longint qmul(longint c, longint x);
			logic [127:0] p;
			longint m;
			p = 128'(absval(c)) * 128'(absval(x));
			p = (p + 128'h8000) >> 16;
			m = (p > 128'(64'd1 << 48)) ? (64'sd1 <<< 48) : longint'(p[63:0]);
			return ((c < 0) != (x < 0)) ? -m : m;
		endfunction

		function longint qdiv(longint c, longint d);
			logic [127:0] nm, q;
			logic [127:0] dm;
			longint m;
			nm = 128'(absval(c)) << 24;
			dm = 128'(absval(d));
			q = nm / dm;
			if ((nm % dm) * 2 >= dm)
				q = q + 1;
			m = (q > 128'(64'd1 << 48)) ? (64'sd1 <<< 48) : longint'(q[63:0]);
			return clamp(((c < 0) != (d < 0)) ? -m : m);
		endfunction

		function void note_point(logic signed [COORD_W-1:0] x, logic last);
			longint poly[MAX_POINTS + 1];
			longint den, diff, coef;
			int deg;
			bit dup;
			coef_t e;
			if (n_points < MAX_POINTS) begin
				points[n_points] = longint'(x);
				n_points++;
			end
			if (!last)
				return;
			bursts++;
			for (int j = 0; j < n_points; j++) begin
				foreach (poly[t]) poly[t] = 0;
				poly[0] = 64'sd1 <<< 24;
				den = 64'sd1 <<< 24;
				dup = 0;
				deg = 0;
				for (int k = 0; k < n_points; k++) begin
					if (k == j)
						continue;
					for (int t = deg + 1; t >= 1; t--)
						poly[t] = clamp(poly[t] - qmul(poly[t - 1], points[k]));
					deg++;
					diff = points[j] - points[k];
					if (diff == 0)
						dup = 1;
					den = clamp(qmul(den, diff));
				end
				for (int k = 0; k < n_points; k++) begin
					if (dup)
						coef = 0;
					else if (den == 0)
						coef = poly[k] == 0 ? 0 : (poly[k] > 0 ? 64'sh7FFF_FFFF_FFFF
							: -64'sh8000_0000_0000);
					else
						coef = qdiv(poly[k], den);
					e.point_index = IDX_W'(j);
					e.power_index = IDX_W'(k);
					e.coefficient = coef[COEF_W-1:0];
					e.zero_denominator = dup;
					e.last_result = (j == n_points - 1) && (k == n_points - 1);
					pending.push_back(e);
				end
			end
			n_points = 0;
		endfunction

		function void check_coef(coef_t got);
			coef_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected coefficient %p", got);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p got %p", e, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, last_point;
	logic signed [COORD_W-1:0] coordinate;
	logic out_valid, out_stall;
	logic [IDX_W-1:0] point_index, power_index;
	logic signed [COEF_W-1:0] coefficient;
	logic zero_denominator, last_result;

	basis_scoreboard coefs = new();
	int send_idle, recv_idle;
	longint cycles;
	int phase_recv[3] = '{76, 13, 0};
	int phase_send[3] = '{13, 76, 0};

	lagrange_basis_coefficients DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// receiver side: sample at rising edge, change stall at falling
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			coefs.check_coef({point_index, power_index, coefficient,
				zero_denominator, last_result});

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle);

	// valid stays high into the next request unless an idle gap is drawn; it drops after the last point of a set
	task automatic send_point(logic signed [COORD_W-1:0] x, logic last);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		coordinate <= x;
		last_point <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		coefs.note_point(x, last);
		@(negedge clk);
		if (last) begin
			in_valid <= 0;
			@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		while (coefs.pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_set(int n, int style);
		logic signed [COORD_W-1:0] x;
		for (int i = 0; i < n; i++) begin
			case (style)
				0: x = $urandom;
				1: x = $signed($urandom_range(16)) - 8 <<< 16;
				default: x = ($signed($urandom_range(200)) - 100) <<< 14;
			endcase
			send_point(x, i == n - 1);
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		coordinate = 0;
		last_point = 0;
		out_stall = 0;
		send_idle = 0;
		recv_idle = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: single point, extremes, duplicates, overflow of the store
		send_point(32'sh7FFF_FFFF, 1);
		send_point(-32'sh8000_0000, 0);
		send_point(32'sh7FFF_FFFF, 1);
		send_point(32'sh0001_0000, 0);
		send_point(32'sh0001_0000, 0);
		send_point(32'sh0002_0000, 1);
		send_point(32'sh0000_0000, 0);
		send_point(32'sh0000_0001, 1);
		for (int i = 0; i < 10; i++)
			send_point((i - 4) <<< 16, i == 9);
		wait_drained();

		for (int p = 0; p < 3; p++) begin
			send_idle = phase_send[p];
			recv_idle = phase_recv[p];
			for (int s = 0; s < 26; s++) begin
				int n;
				int r;
				r = $urandom_range(9);
				n = (r == 0) ? 9 + $urandom_range(2) : 1 + $urandom_range(7);
				send_set(n, $urandom_range(2));
			end
			wait_drained();
		end
		wait_drained();
		repeat (200) @(negedge clk);

		$display("checked %0d coefficients over %0d point sets, %0d mismatches",
			coefs.checked, coefs.bursts, coefs.mismatches);
		if (coefs.mismatches == 0 && coefs.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/lbc_pkg.sv
hdl/lbc_mul.sv
hdl/lbc_div.sv
hdl/lagrange_basis_coefficients.sv
tb/lagrange_basis_coefficients_test.sv
